// ----- rtl/chm_pkg.sv -----
package chm_pkg;

   localparam int MAX_BUCKETS      = 64;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int VALUE_W          = 64;
   localparam int CFG_W            = 7;

   localparam int BKT_W      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int DIV_W      = $clog2(MAX_BUCKETS + 1);
   localparam int SLOT_W     = VALUE_W + 1;
   localparam int ROW_W      = SLOTS_PER_BUCKET * SLOT_W;
   localparam int SLOT_IDX_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

   localparam int BITS_PER_STEP = 8;
   localparam int MOD_STEPS     = VALUE_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic start;
   } mod_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mod_sts_type;

   function automatic logic [DIV_W-1:0] eff_buckets(input logic [CFG_W-1:0] n);
      logic [DIV_W-1:0] r;
      if (n == '0) begin
         r = DIV_W'(1);
      end else if (int'(n) > MAX_BUCKETS) begin
         r = DIV_W'(MAX_BUCKETS);
      end else begin
         r = DIV_W'(n);
      end
      return r;
   endfunction

endpackage

// ----- rtl/chm_slot_ram.sv -----
module chm_slot_ram #(
   parameter int WIDTH = chm_pkg::ROW_W,
   parameter int DEPTH = chm_pkg::MAX_BUCKETS,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/chm_mod_unit.sv -----
module chm_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  chm_pkg::mod_ctl_type        ctl,
   input  logic [chm_pkg::VALUE_W-1:0] value,
   input  logic [chm_pkg::DIV_W-1:0]   divisor,
   output chm_pkg::mod_sts_type        sts,
   output logic [chm_pkg::BKT_W-1:0]   remainder
);

   logic [chm_pkg::VALUE_W-1:0]    mag_ff;
   logic [chm_pkg::BKT_W-1:0]      rem_ff;
   logic [chm_pkg::STEP_CNT_W-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;
   logic [chm_pkg::BKT_W-1:0]      rem_in;
   logic [chm_pkg::VALUE_W-1:0]    mag_start;

   // magnitude, most negative value maps to 2^63
   assign mag_start = value[chm_pkg::VALUE_W-1] ? (~value + chm_pkg::VALUE_W'(1)) : value;

   // one bit per restoring step, several steps per cycle
   always_comb begin
      logic [chm_pkg::BKT_W:0] t;
      logic [chm_pkg::BKT_W-1:0] r;
      r = rem_ff;
      for (int j = 0; j < chm_pkg::BITS_PER_STEP; j++) begin
         t = {r, mag_ff[chm_pkg::VALUE_W-1-j]};
         if (t >= (chm_pkg::BKT_W+1)'(divisor)) begin
            t = t - (chm_pkg::BKT_W+1)'(divisor);
         end
         r = t[chm_pkg::BKT_W-1:0];
      end
      rem_in = r;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (ctl.start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         mag_ff  <= mag_start;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         mag_ff <= mag_ff << chm_pkg::BITS_PER_STEP;
         rem_ff <= rem_in;
         cnt_ff <= cnt_ff + chm_pkg::STEP_CNT_W'(1);
         if (cnt_ff == chm_pkg::STEP_CNT_W'(chm_pkg::MOD_STEPS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign sts.busy  = busy_ff;
   assign sts.done  = done_ff;
   assign remainder = rem_ff;

endmodule

// ----- rtl/chained_hash_multiset.sv -----
// Hash multiset of signed 64-bit keys, one bucket row of slots per memory word.
// Request channel req_*: tuser carries the operation (insert, lookup, remove),
// tdata the key. Result channel rsp_*: tdata carries the 2-bit status
// (ok or found, not found, bucket full).
// csr_* sets the bucket count (register 0, byte address 0); the user is to write it
// only while the block idles, as the block does not enforce this. One item is in
// work at a time. After acceptance the bucket index is the key magnitude modulo
// the bucket count, worked out 8 bits per cycle; the bucket row is then read from
// the slot memory into its read register, and the result is registered and the row
// written back together once the result output register is free. The next item is
// taken in the cycle after the result is registered.
// After reset the block clears the valid bits of every bucket row, one row a
// cycle, and holds req_tready low meanwhile.
// A stalled receiver holds the result in the output register; the block may
// take and work one more item, and then waits before write-back until the
// waiting result is taken.
module chained_hash_multiset (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // value
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // status, zero fill
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HASH,
      S_UPDATE
   } state_type;

   state_type                      state_ff;
   logic [chm_pkg::BKT_W-1:0]      clr_cnt_ff;
   chm_pkg::op_type                op_ff;
   logic [chm_pkg::VALUE_W-1:0]    key_ff;
   logic                           rsp_tvalid_ff;
   logic [1:0]                     rsp_status_ff;
   logic [chm_pkg::CFG_W-1:0]      num_buckets_ff;

   logic                           accept;
   logic                           can_emit;
   chm_pkg::mod_ctl_type           mod_ctl;
   chm_pkg::mod_sts_type           mod_sts;
   logic [chm_pkg::BKT_W-1:0]      bucket;
   logic                           ram_we;
   logic [chm_pkg::BKT_W-1:0]      ram_waddr;
   logic [chm_pkg::ROW_W-1:0]      ram_wdata;
   logic [chm_pkg::ROW_W-1:0]      row_rd;
   logic [chm_pkg::ROW_W-1:0]      row_new;
   logic                           row_wr;
   logic [1:0]                     status_in;

   // config port
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_buckets_ff <= chm_pkg::CFG_W'(chm_pkg::MAX_BUCKETS);
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         num_buckets_ff <= csr_pwdata[chm_pkg::CFG_W-1:0];
      end
   end

   assign csr_prdata = csr_paddr[2] ? 32'd0 : 32'(num_buckets_ff);

   // hashing
   assign accept        = req_tvalid && req_tready;
   assign mod_ctl.start = accept;

   chm_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mod_ctl),
      .value     (req_tdata),
      .divisor   (chm_pkg::eff_buckets(num_buckets_ff)),
      .sts       (mod_sts),
      .remainder (bucket)
   );

   chm_slot_ram #(
      .WIDTH (chm_pkg::ROW_W),
      .DEPTH (chm_pkg::MAX_BUCKETS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (bucket),
      .rd_data (row_rd)
   );

   // bucket row search and update
   always_comb begin
      logic                              found;
      logic [chm_pkg::SLOT_IDX_W-1:0]    idx;
      logic                              vld;
      logic [chm_pkg::VALUE_W-1:0]       sv;
      found     = 1'b0;
      idx       = '0;
      row_new   = row_rd;
      row_wr    = 1'b0;
      status_in = chm_pkg::ST_NOT_FOUND;
      for (int i = 0; i < chm_pkg::SLOTS_PER_BUCKET; i++) begin
         vld = row_rd[i*chm_pkg::SLOT_W + chm_pkg::VALUE_W];
         sv  = row_rd[i*chm_pkg::SLOT_W +: chm_pkg::VALUE_W];
         if (!found) begin
            if (op_ff == chm_pkg::OP_INSERT && !vld) begin
               found = 1'b1;
               idx   = chm_pkg::SLOT_IDX_W'(i);
            end else if ((op_ff == chm_pkg::OP_LOOKUP || op_ff == chm_pkg::OP_REMOVE)
                         && vld && sv == key_ff) begin
               found = 1'b1;
               idx   = chm_pkg::SLOT_IDX_W'(i);
            end
         end
      end
      case (op_ff)
         chm_pkg::OP_INSERT: begin
            if (found) begin
               status_in = chm_pkg::ST_OK;
               row_wr    = 1'b1;
               row_new[idx*chm_pkg::SLOT_W +: chm_pkg::SLOT_W] = {1'b1, key_ff};
            end else begin
               status_in = chm_pkg::ST_FULL;
            end
         end
         chm_pkg::OP_LOOKUP: begin
            if (found) begin
               status_in = chm_pkg::ST_OK;
            end
         end
         chm_pkg::OP_REMOVE: begin
            if (found) begin
               status_in = chm_pkg::ST_OK;
               row_wr    = 1'b1;
               row_new[idx*chm_pkg::SLOT_W + chm_pkg::VALUE_W] = 1'b0;
            end
         end
         default: begin
            status_in = chm_pkg::ST_NOT_FOUND;
         end
      endcase
   end

   assign can_emit = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = bucket;
      ram_wdata = row_new;
      if (state_ff == S_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (state_ff == S_UPDATE && can_emit) begin
         ram_we = row_wr;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready && !(state_ff == S_UPDATE && can_emit)) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + chm_pkg::BKT_W'(1);
               if (clr_cnt_ff == chm_pkg::BKT_W'(chm_pkg::MAX_BUCKETS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= chm_pkg::op_type'(req_tuser);
                  key_ff   <= req_tdata;
                  state_ff <= S_HASH;
               end
            end
            S_HASH: begin
               if (mod_sts.done) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               if (can_emit) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_status_ff <= status_in;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff};

endmodule

// ----- rtl/chm_checker.sv -----
module chm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3) && (rsp_tdata[7:2] == 6'd0))
      else $error("bad status code");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in work");

   a_no_result_soon: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind chained_hash_multiset chm_checker u_chm_checker (.*);
